// ===== rtl/mme_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and types for the matrix multiply engine
package mme_pkg;

   localparam int MAX_DIM = 64;
   localparam int DIM_W   = $clog2(MAX_DIM);
   localparam int CNT_W   = 7;
   localparam int ADDR_W  = 2 * DIM_W;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ELEM_W  = 16;
   localparam int MUL_W   = 2 * ELEM_W;
   localparam int PROD_W  = 38;
   localparam int CSR_W   = 2;

   localparam logic [CNT_W-1:0] DIM_MAX_VAL = CNT_W'(MAX_DIM);

   // configuration register indexes
   localparam logic [CSR_W-1:0] CSR_ROWS_M  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_COLS_N  = 2'd1;
   localparam logic [CSR_W-1:0] CSR_INNER_K = 2'd2;

   typedef enum logic [1:0] {
      OP_WRITE_A   = 2'd0,
      OP_WRITE_B   = 2'd1,
      OP_REQUEST_C = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_RUN   = 2'd1,
      ST_DRAIN = 2'd2,
      ST_RESP  = 2'd3
   } state_type;

   // dimension registers saturate at the store size
   function automatic logic [CNT_W-1:0] clamp_dim(input logic [CNT_W-1:0] value);
      logic [CNT_W-1:0] result;
      result = value;
      if (value > DIM_MAX_VAL) begin
         result = DIM_MAX_VAL;
      end
      return result;
   endfunction

endpackage

// ===== rtl/matrix_multiply_engine.sv =====
`timescale 1ns / 1ps
// matrix multiply engine: element stores and one shared multiply-accumulate unit
// sequencing: a write of A or B is stored at its accepting edge; a request in range steps
//   through run (none if inner_k is zero), drain and result states, out of range to result
// throughput: one item at a time; busy stays high through the result cycle, so a request
//   holds the engine until its result is shown, while a write leaves busy low
// reset: synchronous, clears the sequencer and sets all dimension registers to 64;
//   store contents stay undefined until written; results cannot be stalled
module matrix_multiply_engine
   import mme_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_opcode,
   input  logic [DIM_W-1:0]         req_row_index,
   input  logic [DIM_W-1:0]         req_col_index,
   input  logic signed [ELEM_W-1:0] req_element_value,
   output logic                     rsp_valid,
   output logic signed [PROD_W-1:0] rsp_product_value,
   output logic                     rsp_out_of_range,
   input  logic                     csr_write_enable,
   input  logic [CSR_W-1:0]         csr_index,
   input  logic [CNT_W-1:0]         csr_write_data
);

   logic [CNT_W-1:0] rows_m_ff, cols_n_ff, inner_k_ff;

   state_type state_ff, state_in;
   logic [DIM_W-1:0] step_ff, step_in;
   logic [DIM_W-1:0] row_ff, col_ff;
   logic             oor_ff, oor_in;
   logic             capture;
   logic             issue;

   logic signed [ELEM_W-1:0] store_a_ff [DEPTH];
   logic signed [ELEM_W-1:0] store_b_ff [DEPTH];
   logic signed [ELEM_W-1:0] a_rd_ff, b_rd_ff;
   logic                     rd_valid_ff;
   logic signed [MUL_W-1:0]  mul_ff;
   logic                     mul_valid_ff;
   logic signed [PROD_W-1:0] acc_ff, acc_in;

   logic accept;
   logic wr_a, wr_b;
   logic req_in_range;
   logic [ADDR_W-1:0] rd_a_addr, rd_b_addr, wr_addr;

   assign accept = start && !busy;
   assign wr_a = accept && (req_opcode == OP_WRITE_A)
                 && ({1'b0, req_row_index} < rows_m_ff)
                 && ({1'b0, req_col_index} < inner_k_ff);
   assign wr_b = accept && (req_opcode == OP_WRITE_B)
                 && ({1'b0, req_row_index} < inner_k_ff)
                 && ({1'b0, req_col_index} < cols_n_ff);
   assign req_in_range = ({1'b0, req_row_index} < rows_m_ff)
                         && ({1'b0, req_col_index} < cols_n_ff);

   assign wr_addr   = {req_row_index, req_col_index};
   assign rd_a_addr = {row_ff, step_ff};
   assign rd_b_addr = {step_ff, col_ff};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m_ff  <= DIM_MAX_VAL;
         cols_n_ff  <= DIM_MAX_VAL;
         inner_k_ff <= DIM_MAX_VAL;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROWS_M:  rows_m_ff  <= clamp_dim(csr_write_data);
            CSR_COLS_N:  cols_n_ff  <= clamp_dim(csr_write_data);
            CSR_INNER_K: inner_k_ff <= clamp_dim(csr_write_data);
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      oor_in   = oor_ff;
      capture  = 1'b0;
      issue    = 1'b0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy    = 1'b0;
            step_in = '0;
            if (start && (req_opcode == OP_REQUEST_C)) begin
               capture = 1'b1;
               oor_in  = !req_in_range;
               if (!req_in_range) begin
                  state_in = ST_RESP;
               end else if (inner_k_ff == '0) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            issue   = 1'b1;
            step_in = step_ff + 1'b1;
            if ({1'b0, step_ff} == inner_k_ff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last products to reach the accumulator
            if (!rd_valid_ff && !mul_valid_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      oor_ff  <= oor_in;
      if (capture) begin
         row_ff <= req_row_index;
         col_ff <= req_col_index;
      end
   end

   // element stores: written from the request port, read by the sequencer
   always_ff @(posedge clock) begin
      if (wr_a) begin
         store_a_ff[wr_addr] <= req_element_value;
      end
      a_rd_ff <= store_a_ff[rd_a_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         store_b_ff[wr_addr] <= req_element_value;
      end
      b_rd_ff <= store_b_ff[rd_b_addr];
   end

   // shared multiply-accumulate unit
   always_comb begin
      acc_in = acc_ff;
      if (capture) begin
         acc_in = '0;
      end else if (mul_valid_ff) begin
         acc_in = acc_ff + PROD_W'(mul_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= issue;
         mul_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= a_rd_ff * b_rd_ff;
      acc_ff <= acc_in;
   end

   assign rsp_valid         = (state_ff == ST_RESP);
   assign rsp_product_value = acc_ff;
   assign rsp_out_of_range  = oor_ff;

`ifndef ASSERT_OFF
   a_resp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_product_value == '0))
      else $error("out-of-range response carries a nonzero product");

   a_request_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == OP_REQUEST_C)) |=> busy)
      else $error("request accepted but engine not busy");

   a_pipe_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rd_valid_ff && !mul_valid_ff))
      else $error("response issued with products still in flight");

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      (wr_a || wr_b) |-> (state_ff == ST_IDLE))
      else $error("store written while a request is running");
`endif

endmodule
